// ----- hdl/complex_divider_unit_macros.svh -----
// Assertion macros for the complex divider.
// Expects clk and rst_n in the scope of use.
`ifndef COMPLEX_DIVIDER_UNIT_MACROS_SVH
`define COMPLEX_DIVIDER_UNIT_MACROS_SVH

// implication in the same cycle
`define CDU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("complex divider check failed");

// implication in the next cycle
`define CDU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("complex divider check failed");

`endif

// ----- hdl/cdu_pkg.sv -----
// Package for the complex divider: shared result status type.
// No dependencies.
package cdu_pkg;

  typedef struct packed {
    logic div_zero;
    logic overflow;
  } cdu_status_t;

endpackage

// ----- hdl/cdu_if.sv -----
// Valid/ready channel interfaces for the complex divider.
// Depends on cdu_pkg.
interface cdu_in_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] num_re;
  logic signed [DATA_WIDTH-1:0] num_im;
  logic signed [DATA_WIDTH-1:0] den_re;
  logic signed [DATA_WIDTH-1:0] den_im;

  modport source (output valid, num_re, num_im, den_re, den_im, input ready);
  modport sink   (input valid, num_re, num_im, den_re, den_im, output ready);
endinterface

interface cdu_out_if import cdu_pkg::*; #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quot_re;
  logic signed [DATA_WIDTH-1:0] quot_im;
  cdu_status_t                  status;

  modport source (output valid, quot_re, quot_im, status, input ready);
  modport sink   (input valid, quot_re, quot_im, status, output ready);
endinterface

// ----- hdl/complex_divider_unit.sv -----
// Complex divider, Smith's method, fully pipelined, one transfer per cycle.
// Stages in order: input registers, bit-serial restoring ratio divider, products,
// sums, magnitudes, bit-serial restoring quotient divider, saturation and sign.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Reset (rst_n, synchronous, active low) clears all stage valid bits.
// Depends on cdu_pkg, cdu_if and complex_divider_unit_macros.svh.
`include "complex_divider_unit_macros.svh"

module complex_divider_unit import cdu_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  cdu_in_if.sink     in_ch,
  cdu_out_if.source  out_ch
);

  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int RQ = FB + 1;
  localparam int QB = DW + 1;
  localparam int NW = DW + 2;
  localparam int PW = FB + 2 + DW;

  typedef struct packed {
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] sl;
    logic signed [DW-1:0] ss;
    logic [DW-1:0]        ml;
    logic                 swp;
    logic                 rneg;
    logic                 zero;
  } r_ctx_t;

  typedef struct packed {
    logic [QB-1:0] mp;
    logic          neg_re;
    logic          neg_im;
    logic          ovf_re;
    logic          ovf_im;
    logic          zero;
  } q_ctx_t;

  logic en;
  logic out_valid_r;
  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = rst_n && en;

  // input stage
  logic v0_r;
  logic signed [DW-1:0] a0_r, b0_r, c0_r, d0_r;

  // ratio divider
  logic          v1_r   [0:RQ];
  r_ctx_t        c1_r   [0:RQ];
  logic [DW-1:0] rem1_r [0:RQ];
  logic [RQ-1:0] x1_r   [0:RQ];
  logic [RQ-1:0] q1_r   [0:RQ];
  r_ctx_t        c1_nxt [0:RQ];
  logic [DW-1:0] rem1_nxt [0:RQ];
  logic [RQ-1:0] x1_nxt [0:RQ];
  logic [RQ-1:0] q1_nxt [0:RQ];

  always_comb begin
    logic [DW-1:0] mc, md, ms;
    logic [DW:0]   t;
    logic          ge;
    mc = c0_r[DW-1] ? DW'(-c0_r) : DW'(c0_r);
    md = d0_r[DW-1] ? DW'(-d0_r) : DW'(d0_r);
    c1_nxt[0].a    = a0_r;
    c1_nxt[0].b    = b0_r;
    c1_nxt[0].swp  = mc < md;
    c1_nxt[0].sl   = c1_nxt[0].swp ? d0_r : c0_r;
    c1_nxt[0].ss   = c1_nxt[0].swp ? c0_r : d0_r;
    c1_nxt[0].ml   = c1_nxt[0].swp ? md : mc;
    c1_nxt[0].rneg = c1_nxt[0].sl[DW-1] ^ c1_nxt[0].ss[DW-1];
    c1_nxt[0].zero = (c0_r == '0) && (d0_r == '0);
    ms = c1_nxt[0].swp ? mc : md;
    rem1_nxt[0] = {1'b0, ms[DW-1:1]};
    x1_nxt[0]   = {ms[0], {FB{1'b0}}};
    q1_nxt[0]   = '0;
    for (int k = 1; k <= RQ; k++) begin
      t  = {rem1_r[k-1], x1_r[k-1][RQ-1]};
      ge = t >= {1'b0, c1_r[k-1].ml};
      c1_nxt[k]   = c1_r[k-1];
      rem1_nxt[k] = ge ? DW'(t - {1'b0, c1_r[k-1].ml}) : DW'(t);
      x1_nxt[k]   = {x1_r[k-1][RQ-2:0], 1'b0};
      q1_nxt[k]   = {q1_r[k-1][RQ-2:0], ge};
    end
  end

  // products
  logic   vm_r;
  r_ctx_t cm_r;
  logic signed [NW-1:0] ps_r, pa_r, pb_r;
  logic signed [NW-1:0] ps_nxt, pa_nxt, pb_nxt;

  always_comb begin
    logic signed [FB+1:0] rs;
    logic signed [PW-1:0] pr_s, pr_a, pr_b;
    rs = c1_r[RQ].rneg ? -$signed({1'b0, q1_r[RQ]}) : $signed({1'b0, q1_r[RQ]});
    pr_s = rs * c1_r[RQ].ss;
    pr_a = rs * c1_r[RQ].a;
    pr_b = rs * c1_r[RQ].b;
    ps_nxt = NW'(pr_s >>> FB);
    pa_nxt = NW'(pr_a >>> FB);
    pb_nxt = NW'(pr_b >>> FB);
  end

  // sums
  logic vs_r, zs_r;
  logic signed [NW-1:0] p_r, nre_r, nim_r;
  logic signed [NW-1:0] p_nxt, nre_nxt, nim_nxt;

  always_comb begin
    p_nxt   = NW'(cm_r.sl) + ps_r;
    nre_nxt = cm_r.swp ? pa_r + NW'(cm_r.b) : NW'(cm_r.a) + pb_r;
    nim_nxt = cm_r.swp ? pb_r - NW'(cm_r.a) : NW'(cm_r.b) - pa_r;
  end

  // magnitudes
  logic vg_r, zg_r, ngre_r, ngim_r;
  logic [QB-1:0] mre_r, mim_r, mpg_r;

  // quotient divider
  logic          v2_r     [0:QB];
  q_ctx_t        c2_r     [0:QB];
  logic [QB-1:0] rre_r    [0:QB];
  logic [QB-1:0] rim_r    [0:QB];
  logic [QB-1:0] xre_r    [0:QB];
  logic [QB-1:0] xim_r    [0:QB];
  logic [QB-1:0] qre_r    [0:QB];
  logic [QB-1:0] qim_r    [0:QB];
  q_ctx_t        c2_nxt   [0:QB];
  logic [QB-1:0] rre_nxt  [0:QB];
  logic [QB-1:0] rim_nxt  [0:QB];
  logic [QB-1:0] xre_nxt  [0:QB];
  logic [QB-1:0] xim_nxt  [0:QB];
  logic [QB-1:0] qre_nxt  [0:QB];
  logic [QB-1:0] qim_nxt  [0:QB];

  always_comb begin
    logic [QB:0] tr, ti;
    logic        gr, gi;
    rre_nxt[0] = QB'(mre_r[QB-1:QB-FB]);
    rim_nxt[0] = QB'(mim_r[QB-1:QB-FB]);
    xre_nxt[0] = {mre_r[QB-FB-1:0], {FB{1'b0}}};
    xim_nxt[0] = {mim_r[QB-FB-1:0], {FB{1'b0}}};
    qre_nxt[0] = '0;
    qim_nxt[0] = '0;
    c2_nxt[0].mp     = mpg_r;
    c2_nxt[0].neg_re = ngre_r;
    c2_nxt[0].neg_im = ngim_r;
    c2_nxt[0].ovf_re = QB'(mre_r[QB-1:QB-FB]) >= mpg_r;
    c2_nxt[0].ovf_im = QB'(mim_r[QB-1:QB-FB]) >= mpg_r;
    c2_nxt[0].zero   = zg_r;
    for (int k = 1; k <= QB; k++) begin
      tr = {rre_r[k-1], xre_r[k-1][QB-1]};
      ti = {rim_r[k-1], xim_r[k-1][QB-1]};
      gr = tr >= {1'b0, c2_r[k-1].mp};
      gi = ti >= {1'b0, c2_r[k-1].mp};
      c2_nxt[k]  = c2_r[k-1];
      rre_nxt[k] = gr ? QB'(tr - {1'b0, c2_r[k-1].mp}) : QB'(tr);
      rim_nxt[k] = gi ? QB'(ti - {1'b0, c2_r[k-1].mp}) : QB'(ti);
      xre_nxt[k] = {xre_r[k-1][QB-2:0], 1'b0};
      xim_nxt[k] = {xim_r[k-1][QB-2:0], 1'b0};
      qre_nxt[k] = {qre_r[k-1][QB-2:0], gr};
      qim_nxt[k] = {qim_r[k-1][QB-2:0], gi};
    end
  end

  // saturation and sign
  logic signed [DW-1:0] qre_o_nxt, qim_o_nxt, qre_o_r, qim_o_r;
  cdu_status_t st_nxt, st_r;

  always_comb begin
    logic [QB-1:0] lr, li, mr, mi;
    logic          sr, si;
    lr = c2_r[QB].neg_re ? (QB'(1) << (DW-1)) : (QB'(1) << (DW-1)) - QB'(1);
    li = c2_r[QB].neg_im ? (QB'(1) << (DW-1)) : (QB'(1) << (DW-1)) - QB'(1);
    sr = c2_r[QB].ovf_re || (qre_r[QB] > lr);
    si = c2_r[QB].ovf_im || (qim_r[QB] > li);
    mr = sr ? lr : qre_r[QB];
    mi = si ? li : qim_r[QB];
    qre_o_nxt = c2_r[QB].neg_re ? DW'(-mr) : DW'(mr);
    qim_o_nxt = c2_r[QB].neg_im ? DW'(-mi) : DW'(mi);
    st_nxt.div_zero = c2_r[QB].zero;
    st_nxt.overflow = (sr || si) && !c2_r[QB].zero;
    if (c2_r[QB].zero) begin
      qre_o_nxt = '0;
      qim_o_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      vm_r <= 1'b0;
      vs_r <= 1'b0;
      vg_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= RQ; k++) v1_r[k] <= 1'b0;
      for (int k = 0; k <= QB; k++) v2_r[k] <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid;
      v1_r[0] <= v0_r;
      for (int k = 1; k <= RQ; k++) v1_r[k] <= v1_r[k-1];
      vm_r <= v1_r[RQ];
      vs_r <= vm_r;
      vg_r <= vs_r;
      v2_r[0] <= vg_r;
      for (int k = 1; k <= QB; k++) v2_r[k] <= v2_r[k-1];
      out_valid_r <= v2_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r <= in_ch.num_re;
      b0_r <= in_ch.num_im;
      c0_r <= in_ch.den_re;
      d0_r <= in_ch.den_im;
      for (int k = 0; k <= RQ; k++) begin
        c1_r[k]   <= c1_nxt[k];
        rem1_r[k] <= rem1_nxt[k];
        x1_r[k]   <= x1_nxt[k];
        q1_r[k]   <= q1_nxt[k];
      end
      cm_r <= c1_r[RQ];
      ps_r <= ps_nxt;
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      zs_r  <= cm_r.zero;
      p_r   <= p_nxt;
      nre_r <= nre_nxt;
      nim_r <= nim_nxt;
      zg_r   <= zs_r;
      ngre_r <= nre_r[NW-1] ^ p_r[NW-1];
      ngim_r <= nim_r[NW-1] ^ p_r[NW-1];
      mre_r  <= nre_r[NW-1] ? QB'(-nre_r) : QB'(nre_r);
      mim_r  <= nim_r[NW-1] ? QB'(-nim_r) : QB'(nim_r);
      mpg_r  <= p_r[NW-1] ? QB'(-p_r) : QB'(p_r);
      for (int k = 0; k <= QB; k++) begin
        c2_r[k]  <= c2_nxt[k];
        rre_r[k] <= rre_nxt[k];
        rim_r[k] <= rim_nxt[k];
        xre_r[k] <= xre_nxt[k];
        xim_r[k] <= xim_nxt[k];
        qre_r[k] <= qre_nxt[k];
        qim_r[k] <= qim_nxt[k];
      end
      qre_o_r <= qre_o_nxt;
      qim_o_r <= qim_o_nxt;
      st_r    <= st_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.quot_re = qre_o_r;
  assign out_ch.quot_im = qim_o_r;
  assign out_ch.status  = st_r;

  `CDU_ASSERT_NOW(a_ratio_bound, v1_r[RQ] && !c1_r[RQ].zero, q1_r[RQ] <= (RQ'(1) << FB))
  `CDU_ASSERT_NOW(a_rem_below_div, v2_r[QB] && !c2_r[QB].zero && !c2_r[QB].ovf_re, rre_r[QB] < c2_r[QB].mp)
  `CDU_ASSERT_NOW(a_zero_result, out_valid_r && st_r.div_zero, qre_o_r == '0 && qim_o_r == '0 && !st_r.overflow)
  `CDU_ASSERT_NEXT(a_ovf_saturates, v2_r[QB] && en && st_nxt.overflow, qre_o_r == $signed({1'b0, {(DW-1){1'b1}}}) || qre_o_r == $signed({1'b1, {(DW-1){1'b0}}}) || qim_o_r == $signed({1'b0, {(DW-1){1'b1}}}) || qim_o_r == $signed({1'b1, {(DW-1){1'b0}}}))

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for complex_divider_unit (Smith complex division, Q16.16).
// Depends on cdu_pkg, cdu_if and complex_divider_unit from the RTL; a local predictor sets the expected
// quotients and flags.
module tb;
  import cdu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_WIDTH = 32;
  localparam int LATENCY    = FRAC_BITS + DATA_WIDTH + 8;
  localparam longint CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [31:0] MAX_POS = 32'h7fffffff;
  localparam logic [31:0] MAX_NEG = 32'h80000000;
  localparam logic [31:0] Q_ONE   = 32'h00010000;

  typedef struct {
    logic [DATA_WIDTH-1:0] re;
    logic [DATA_WIDTH-1:0] im;
    logic                  dz;
    logic                  ov;
  } quot_t;

  logic clk;
  logic rst_n;

  cdu_in_if  #(.DATA_WIDTH(DATA_WIDTH)) in_ch();
  cdu_out_if #(.DATA_WIDTH(DATA_WIDTH)) out_ch();

  complex_divider_unit #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  quot_t  pending_quots[$];
  int     mismatches = 0;
  longint cycles = 0;
  int     snd_pct;
  int     rcv_pct;
  int     hold_reqs = 0;
  int     hold_seen = 0;
  int     hold_cnt = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------- predictor ----------------
  function automatic longint unsigned mag_of(longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint unsigned frac_div(longint unsigned n, longint unsigned den,
                                                longint unsigned limit, inout bit sat);
    longint unsigned q;
    longint unsigned rem;
    if (den == 0) begin
      sat = 1'b1;
      return limit;
    end
    q   = n / den;
    rem = n % den;
    if (q > (limit >> FRAC_BITS)) begin
      sat = 1'b1;
      return limit;
    end
    q = (q << FRAC_BITS) + ((rem << FRAC_BITS) / den);
    if (q > limit) begin
      sat = 1'b1;
      return limit;
    end
    return q;
  endfunction

  function automatic longint scale_by(longint r, longint x);
    return (r * x) >>> FRAC_BITS;
  endfunction

  function automatic longint signed_quot(longint n, longint p, inout bit sat);
    bit neg;
    longint unsigned limit;
    longint unsigned m;
    neg   = (n < 0) != (p < 0);
    limit = neg ? (64'd1 << (DATA_WIDTH - 1)) : ((64'd1 << (DATA_WIDTH - 1)) - 1);
    m     = frac_div(mag_of(n), mag_of(p), limit, sat);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint smith_ratio(longint sm, longint lg);
    bit dummy;
    longint unsigned m;
    dummy = 1'b0;
    m = frac_div(mag_of(sm), mag_of(lg), 64'd1 << FRAC_BITS, dummy);
    return ((sm < 0) != (lg < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic quot_t smith_divide(logic signed [31:0] a_i, logic signed [31:0] b_i,
                                         logic signed [31:0] c_i, logic signed [31:0] d_i);
    quot_t  q;
    longint a, b, c, d, r, p, nre, nim;
    bit     sat;
    a = a_i; b = b_i; c = c_i; d = d_i;
    sat = 1'b0;
    q.re = '0; q.im = '0; q.dz = 1'b1; q.ov = 1'b0;
    if (c == 0 && d == 0) return q;
    if (mag_of(c) >= mag_of(d)) begin
      r   = smith_ratio(d, c);
      p   = c + scale_by(r, d);
      nre = a + scale_by(r, b);
      nim = b - scale_by(r, a);
    end else begin
      r   = smith_ratio(c, d);
      p   = d + scale_by(r, c);
      nre = scale_by(r, a) + b;
      nim = scale_by(r, b) - a;
    end
    q.re = 32'(signed_quot(nre, p, sat));
    q.im = 32'(signed_quot(nim, p, sat));
    q.dz = 1'b0;
    q.ov = sat;
    return q;
  endfunction

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------- result side ----------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen    <= hold_reqs;
      hold_cnt     <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt     <= hold_cnt - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_pct);
    end
  end

  always @(posedge clk) begin
    quot_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_quots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: unexpected result transfer");
      end else begin
        want = pending_quots.pop_front();
        if (out_ch.quot_re !== want.re || out_ch.quot_im !== want.im ||
            out_ch.status.div_zero !== want.dz || out_ch.status.overflow !== want.ov) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: mismatch exp re=%h im=%h dz=%b ov=%b got re=%h im=%h dz=%b ov=%b",
                     want.re, want.im, want.dz, want.ov, out_ch.quot_re, out_ch.quot_im,
                     out_ch.status.div_zero, out_ch.status.overflow);
        end
      end
    end
  end

  // ---------------- input side ----------------
  task automatic send_item(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
    int gap;
    if ($urandom_range(0, 99) < snd_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.num_re <= a;
    in_ch.num_im <= b;
    in_ch.den_re <= c;
    in_ch.den_im <= d;
    do @(posedge clk); while (!in_ch.ready);
    pending_quots.push_back(smith_divide(a, b, c, d));
  endtask

  task automatic wait_empty();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_quots.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return MAX_POS;
      2: return MAX_NEG;
      3: return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
      4: return $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 255)))
                                     : -32'(int'($urandom_range(0, 255)));
      5: return 32'($signed($urandom_range(0, 32'h003fffff)) - 32'sh00200000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic [31:0] c, d;
    c = pick_val();
    d = pick_val();
    case ($urandom_range(0, 5))
      0: d = $urandom_range(0, 1) ? c : -c;
      1: d = '0;
      2: c = '0;
      default: ;
    endcase
    send_item(pick_val(), pick_val(), c, d);
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    snd_pct = 0; rcv_pct = 0;
    send_item(Q_ONE, Q_ONE, '0, '0);
    send_item(MAX_POS, MAX_NEG, '0, '0);
    send_item(Q_ONE, '0, Q_ONE, '0);
    send_item(Q_ONE, Q_ONE, '0, Q_ONE);
    send_item(Q_ONE, -Q_ONE, Q_ONE, Q_ONE);
    send_item(Q_ONE, Q_ONE, -Q_ONE, Q_ONE);
    send_item(MAX_POS, MAX_POS, 32'd1, '0);
    send_item(MAX_NEG, MAX_NEG, '0, 32'd1);
    send_item(MAX_NEG, '0, -32'd1, '0);
    send_item(MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
    send_item(MAX_POS, MAX_NEG, MAX_POS, MAX_NEG);
    send_item(MAX_POS, MAX_POS, MAX_POS, MAX_POS);
    send_item(MAX_NEG, MAX_POS, MAX_NEG, '0);
    send_item('0, '0, MAX_POS, 32'd1);
    send_item(32'd1, 32'd1, MAX_POS, MAX_POS);
    send_item(32'd3, -32'd7, 32'd5, -32'd2);
    send_item(32'h00030000, 32'h00040000, 32'h00010000, 32'h00020000);
    send_item(-32'd1, -32'd1, 32'd1, -32'd1);
    send_item(32'hdeadbeef, 32'h12345678, 32'h00000100, 32'hffffff00);
    send_item(MAX_POS, '0, 32'd1, 32'd1);
    wait_empty();
  endtask

  task automatic test_random(int n, int s_pct, int r_pct);
    snd_pct = s_pct; rcv_pct = r_pct;
    repeat (n) send_random();
  endtask

  task automatic test_backpressure();
    snd_pct = 0; rcv_pct = 0;
    hold_reqs++;
    repeat (120) send_random();
    wait_empty();
  endtask

  initial begin
    rst_n        = 1'b0;
    snd_pct      = 0;
    rcv_pct      = 0;
    in_ch.valid  = 1'b0;
    in_ch.num_re = '0;
    in_ch.num_im = '0;
    in_ch.den_re = '0;
    in_ch.den_im = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(200, 0, 0);
    test_random(200, 63, 0);
    wait_empty();
    test_random(200, 0, 63);
    test_random(200, 13, 13);
    test_backpressure();

    wait_empty();
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && pending_quots.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
